// File: sv/circle_pair_collision_response_unit_assert.svh
// Assertion macros shared by the circle pair collision response RTL.
// Included by modules that carry concurrent checks; needs no package.
`ifndef CIRCLE_PAIR_COLLISION_RESPONSE_UNIT_ASSERT_SVH
`define CIRCLE_PAIR_COLLISION_RESPONSE_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is held
`define CPCR_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("cpcr same-cycle check failed");

// Next-cycle implication, disabled while reset is held
`define CPCR_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("cpcr next-cycle check failed");

`endif

// File: sv/cpcr_pkg.sv
// Types, constants and helpers of the circle pair collision response unit.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps

package cpcr_pkg;

    localparam int SQRT_STEPS = 32;
    localparam int QUOT_BITS  = 17;

    localparam logic [16:0] RESTITUTION_ONE = 17'd65536;

    // Configuration register indexes
    localparam logic CFG_RESTITUTION  = 1'b0;
    localparam logic CFG_MIN_DISTANCE = 1'b1;

    localparam logic signed [47:0] SAT_MAX = 48'sh0000_7FFF_FFFF;
    localparam logic signed [47:0] SAT_MIN = -48'sh0000_8000_0000;

    // One input pair as it arrives
    typedef struct packed {
        logic signed [31:0] first_x;
        logic signed [31:0] first_y;
        logic signed [31:0] first_vx;
        logic signed [31:0] first_vy;
        logic        [30:0] first_radius;
        logic signed [31:0] second_x;
        logic signed [31:0] second_y;
        logic signed [31:0] second_vx;
        logic signed [31:0] second_vy;
        logic        [30:0] second_radius;
    } t_pair;

    // Context that travels down the pipeline with each pair
    typedef struct packed {
        logic signed [31:0] x1;
        logic signed [31:0] y1;
        logic signed [31:0] vx1;
        logic signed [31:0] vy1;
        logic signed [31:0] x2;
        logic signed [31:0] y2;
        logic signed [31:0] vx2;
        logic signed [31:0] vy2;
        logic signed [32:0] dx;
        logic signed [32:0] dy;
        logic        [31:0] comb;
        logic               gate;
        logic        [31:0] center_dist;
        logic               contact;
    } t_body;

    // One resolved pair
    typedef struct packed {
        logic signed [31:0] new_first_x;
        logic signed [31:0] new_first_y;
        logic signed [31:0] new_first_vx;
        logic signed [31:0] new_first_vy;
        logic signed [31:0] new_second_x;
        logic signed [31:0] new_second_y;
        logic signed [31:0] new_second_vx;
        logic signed [31:0] new_second_vy;
        logic               contact;
        logic               approaching;
    } t_result;

    // Clamp a wide Q16.16 value into the 32-bit range
    function automatic logic signed [31:0] sat_q16(input logic signed [47:0] v);
        logic signed [31:0] r;
        if (v > SAT_MAX) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < SAT_MIN) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage

// File: sv/cpcr_front.sv
// Front stages: differences, radius sum, squares and the overlap gate.
// Depends on cpcr_pkg.
`timescale 1ns / 1ps

module cpcr_front (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_en,
    input  logic           i_valid,
    input  cpcr_pkg::t_pair i_pair,
    output logic           o_valid,
    output cpcr_pkg::t_body o_body,
    output logic [63:0]    o_radicand
);
    import cpcr_pkg::*;

    logic [2:0]  r_valid;
    t_body       r_s0_body, r_s1_body, r_s2_body;
    logic [31:0] r_adx, r_ady;
    logic [63:0] r_dx2, r_dy2, r_comb2, r_sum;
    logic        r_pre;

    t_body       n_body;
    t_body       n_s2_body;
    logic [32:0] n_adx, n_ady;

    // Form differences and radius sum
    always_comb begin
        n_body         = '0;
        n_body.x1      = i_pair.first_x;
        n_body.y1      = i_pair.first_y;
        n_body.vx1     = i_pair.first_vx;
        n_body.vy1     = i_pair.first_vy;
        n_body.x2      = i_pair.second_x;
        n_body.y2      = i_pair.second_y;
        n_body.vx2     = i_pair.second_vx;
        n_body.vy2     = i_pair.second_vy;
        n_body.dx      = 33'(i_pair.second_x) - 33'(i_pair.first_x);
        n_body.dy      = 33'(i_pair.second_y) - 33'(i_pair.first_y);
        n_body.comb    = 32'(i_pair.first_radius) + 32'(i_pair.second_radius);
        n_adx          = n_body.dx[32] ? 33'(-n_body.dx) : 33'(n_body.dx);
        n_ady          = n_body.dy[32] ? 33'(-n_body.dy) : 33'(n_body.dy);
    end

    // Mark pairs whose squared distance lies below the squared radius sum
    always_comb begin
        n_s2_body      = r_s1_body;
        n_s2_body.gate = r_pre && (r_dy2 < (r_comb2 - r_dx2));
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[1:0], i_valid};
        end
    end

    // Three payload stages: abs, squares, gate
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s0_body <= n_body;
            r_adx     <= n_adx[31:0];
            r_ady     <= n_ady[31:0];

            r_s1_body <= r_s0_body;
            r_pre     <= (r_adx < r_s0_body.comb) && (r_ady < r_s0_body.comb);
            r_dx2     <= 64'(r_adx) * 64'(r_adx);
            r_dy2     <= 64'(r_ady) * 64'(r_ady);
            r_comb2   <= 64'(r_s0_body.comb) * 64'(r_s0_body.comb);

            r_s2_body <= n_s2_body;
            r_sum     <= r_dx2 + r_dy2;
        end
    end

    assign o_valid    = r_valid[2];
    assign o_body     = r_s2_body;
    assign o_radicand = r_sum;

endmodule

// File: sv/cpcr_isqrt.sv
// Pipelined integer square root, one result bit per stage.
// Depends on cpcr_pkg; fills the center_dist field of the carried context.
`timescale 1ns / 1ps

module cpcr_isqrt (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  logic            i_valid,
    input  cpcr_pkg::t_body i_body,
    input  logic [63:0]     i_radicand,
    output logic            o_valid,
    output cpcr_pkg::t_body o_body
);
    import cpcr_pkg::*;

    logic [SQRT_STEPS-1:0] r_valid;
    logic [63:0]           r_rem  [0:SQRT_STEPS-1];
    logic [63:0]           r_root [0:SQRT_STEPS-1];
    t_body                 r_body [0:SQRT_STEPS-1];

    logic                  w_valid [0:SQRT_STEPS-1];
    logic [63:0]           w_rem   [0:SQRT_STEPS-1];
    logic [63:0]           w_root  [0:SQRT_STEPS-1];
    t_body                 w_body  [0:SQRT_STEPS-1];

    assign w_valid[0] = i_valid;
    assign w_rem[0]   = i_radicand;
    assign w_root[0]  = '0;
    assign w_body[0]  = i_body;

    genvar k;
    generate
        for (k = 0; k < SQRT_STEPS; k++) begin : g_step
            localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
            logic [63:0] n_trial, n_rem, n_root;

            // Try one root bit
            always_comb begin
                n_trial = w_root[k] + BIT;
                if (w_rem[k] >= n_trial) begin
                    n_rem  = w_rem[k] - n_trial;
                    n_root = (w_root[k] >> 1) + BIT;
                end else begin
                    n_rem  = w_rem[k];
                    n_root = w_root[k] >> 1;
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_valid[k] <= 1'b0;
                end else if (i_en) begin
                    r_valid[k] <= w_valid[k];
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_rem[k]  <= n_rem;
                    r_root[k] <= n_root;
                    r_body[k] <= w_body[k];
                end
            end

            if (k < SQRT_STEPS - 1) begin : g_link
                assign w_valid[k+1] = r_valid[k];
                assign w_rem[k+1]   = r_rem[k];
                assign w_root[k+1]  = r_root[k];
                assign w_body[k+1]  = r_body[k];
            end
        end
    endgenerate

    // Attach the root to the context
    always_comb begin
        o_body             = r_body[SQRT_STEPS-1];
        o_body.center_dist = r_root[SQRT_STEPS-1][31:0];
    end

    assign o_valid = r_valid[SQRT_STEPS-1];

endmodule

// File: sv/cpcr_div.sv
// Contact decision and two restoring dividers for the unit normal.
// Depends on cpcr_pkg; one quotient bit per stage on each axis.
`timescale 1ns / 1ps

module cpcr_div (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic                      i_valid,
    input  cpcr_pkg::t_body           i_body,
    input  logic [16:0]               i_min_distance,
    output logic                      o_valid,
    output cpcr_pkg::t_body           o_body,
    output logic [cpcr_pkg::QUOT_BITS-1:0] o_qx,
    output logic [cpcr_pkg::QUOT_BITS-1:0] o_qy
);
    import cpcr_pkg::*;

    logic        r_e_valid;
    t_body       r_e_body;
    logic [48:0] r_e_remx, r_e_remy;

    t_body       n_e_body;
    logic [32:0] n_adx, n_ady;

    logic [QUOT_BITS-1:0] r_valid;
    logic [48:0]          r_remx [0:QUOT_BITS-1];
    logic [48:0]          r_remy [0:QUOT_BITS-1];
    logic [QUOT_BITS-1:0] r_qx   [0:QUOT_BITS-1];
    logic [QUOT_BITS-1:0] r_qy   [0:QUOT_BITS-1];
    t_body                r_body [0:QUOT_BITS-1];

    logic                 w_valid [0:QUOT_BITS-1];
    logic [48:0]          w_remx  [0:QUOT_BITS-1];
    logic [48:0]          w_remy  [0:QUOT_BITS-1];
    logic [QUOT_BITS-1:0] w_qx    [0:QUOT_BITS-1];
    logic [QUOT_BITS-1:0] w_qy    [0:QUOT_BITS-1];
    t_body                w_body  [0:QUOT_BITS-1];

    assign n_adx = i_body.dx[32] ? 33'(-i_body.dx) : 33'(i_body.dx);
    assign n_ady = i_body.dy[32] ? 33'(-i_body.dy) : 33'(i_body.dy);

    // Decide contact on the incoming context
    always_comb begin
        n_e_body         = i_body;
        n_e_body.contact = i_body.gate && (i_body.center_dist < i_body.comb)
                           && (i_body.center_dist > 32'(i_min_distance));
    end

    // Load the dividends
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_e_valid <= 1'b0;
        end else if (i_en) begin
            r_e_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_e_body <= n_e_body;
            r_e_remx <= {1'b0, n_adx[31:0], 16'd0};
            r_e_remy <= {1'b0, n_ady[31:0], 16'd0};
        end
    end

    assign w_valid[0] = r_e_valid;
    assign w_remx[0]  = r_e_remx;
    assign w_remy[0]  = r_e_remy;
    assign w_qx[0]    = '0;
    assign w_qy[0]    = '0;
    assign w_body[0]  = r_e_body;

    genvar s;
    generate
        for (s = 0; s < QUOT_BITS; s++) begin : g_step
            localparam int J = QUOT_BITS - 1 - s;
            logic [48:0]          n_dsr;
            logic [48:0]          n_remx, n_remy;
            logic [QUOT_BITS-1:0] n_qx, n_qy;

            // Subtract the shifted divisor where it fits
            always_comb begin
                n_dsr  = 49'(w_body[s].center_dist) << J;
                n_remx = w_remx[s];
                n_remy = w_remy[s];
                n_qx   = w_qx[s];
                n_qy   = w_qy[s];
                if (w_remx[s] >= n_dsr) begin
                    n_remx  = w_remx[s] - n_dsr;
                    n_qx[J] = 1'b1;
                end
                if (w_remy[s] >= n_dsr) begin
                    n_remy  = w_remy[s] - n_dsr;
                    n_qy[J] = 1'b1;
                end
            end

            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_valid[s] <= 1'b0;
                end else if (i_en) begin
                    r_valid[s] <= w_valid[s];
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_en) begin
                    r_remx[s] <= n_remx;
                    r_remy[s] <= n_remy;
                    r_qx[s]   <= n_qx;
                    r_qy[s]   <= n_qy;
                    r_body[s] <= w_body[s];
                end
            end

            if (s < QUOT_BITS - 1) begin : g_link
                assign w_valid[s+1] = r_valid[s];
                assign w_remx[s+1]  = r_remx[s];
                assign w_remy[s+1]  = r_remy[s];
                assign w_qx[s+1]    = r_qx[s];
                assign w_qy[s+1]    = r_qy[s];
                assign w_body[s+1]  = r_body[s];
            end
        end
    endgenerate

    assign o_valid = r_valid[QUOT_BITS-1];
    assign o_body  = r_body[QUOT_BITS-1];
    assign o_qx    = r_qx[QUOT_BITS-1];
    assign o_qy    = r_qy[QUOT_BITS-1];

endmodule

// File: sv/cpcr_resolve.sv
// Separation and restitution impulse, ending in the output register.
// Depends on cpcr_pkg and the shared assertion macro header.
`timescale 1ns / 1ps
`include "circle_pair_collision_response_unit_assert.svh"

module cpcr_resolve (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  logic                          i_valid,
    input  cpcr_pkg::t_body               i_body,
    input  logic [cpcr_pkg::QUOT_BITS-1:0] i_qx,
    input  logic [cpcr_pkg::QUOT_BITS-1:0] i_qy,
    input  logic [16:0]                   i_restitution,
    output logic                          o_valid,
    output cpcr_pkg::t_result             o_result
);
    import cpcr_pkg::*;

    logic [5:0] r_valid;

    // Stage 1: signed normal, overlap, velocity difference
    t_body              r_s1_body;
    logic signed [17:0] r_s1_nx, r_s1_ny;
    logic signed [32:0] r_s1_ov, r_s1_dvx, r_s1_dvy;
    // Stage 2: products
    t_body              r_s2_body;
    logic signed [17:0] r_s2_nx, r_s2_ny;
    logic signed [50:0] r_s2_px, r_s2_py, r_s2_qx, r_s2_qy;
    // Stage 3: positions, approach, relative speed
    t_body              r_s3_body;
    logic signed [17:0] r_s3_nx, r_s3_ny;
    logic signed [31:0] r_s3_x1, r_s3_y1, r_s3_x2, r_s3_y2;
    logic               r_s3_appr;
    logic [35:0]        r_s3_negrel;
    // Stage 4: impulse magnitude
    t_body              r_s4_body;
    logic signed [17:0] r_s4_nx, r_s4_ny;
    logic signed [31:0] r_s4_x1, r_s4_y1, r_s4_x2, r_s4_y2;
    logic               r_s4_appr;
    logic [37:0]        r_s4_imp;
    // Stage 5: impulse along the normal
    t_body              r_s5_body;
    logic signed [31:0] r_s5_x1, r_s5_y1, r_s5_x2, r_s5_y2;
    logic               r_s5_appr;
    logic signed [56:0] r_s5_uxp, r_s5_uyp;
    // Output register
    t_result            r_out;

    logic signed [17:0] n_nx, n_ny;
    logic signed [50:0] n_ox, n_oy;
    logic signed [51:0] n_qsum, n_rel;
    logic [17:0]        n_scale;
    logic [53:0]        n_impp;
    logic signed [56:0] n_ux, n_uy;
    t_result            n_out;

    // Apply the normal's sign
    assign n_nx = i_body.dx[32] ? -$signed({1'b0, i_qx}) : $signed({1'b0, i_qx});
    assign n_ny = i_body.dy[32] ? -$signed({1'b0, i_qy}) : $signed({1'b0, i_qy});

    // Truncating shifts toward zero
    assign n_ox   = r_s2_px[50] ? -((-r_s2_px) >>> 17) : (r_s2_px >>> 17);
    assign n_oy   = r_s2_py[50] ? -((-r_s2_py) >>> 17) : (r_s2_py >>> 17);
    assign n_qsum = 52'(r_s2_qx) + 52'(r_s2_qy);
    assign n_rel  = n_qsum[51] ? -((-n_qsum) >>> 16) : (n_qsum >>> 16);

    assign n_scale = 18'(RESTITUTION_ONE)
                     + 18'((i_restitution > RESTITUTION_ONE) ? RESTITUTION_ONE : i_restitution);
    assign n_impp  = 54'(n_scale) * 54'(r_s3_negrel);

    assign n_ux = r_s5_uxp[56] ? -((-r_s5_uxp) >>> 17) : (r_s5_uxp >>> 17);
    assign n_uy = r_s5_uyp[56] ? -((-r_s5_uyp) >>> 17) : (r_s5_uyp >>> 17);

    // Final velocities and flags
    always_comb begin
        n_out               = '0;
        n_out.new_first_x   = r_s5_x1;
        n_out.new_first_y   = r_s5_y1;
        n_out.new_second_x  = r_s5_x2;
        n_out.new_second_y  = r_s5_y2;
        n_out.contact       = r_s5_body.contact;
        n_out.approaching   = r_s5_appr;
        if (r_s5_appr) begin
            n_out.new_first_vx  = sat_q16(48'(r_s5_body.vx1) - 48'(n_ux));
            n_out.new_first_vy  = sat_q16(48'(r_s5_body.vy1) - 48'(n_uy));
            n_out.new_second_vx = sat_q16(48'(r_s5_body.vx2) + 48'(n_ux));
            n_out.new_second_vy = sat_q16(48'(r_s5_body.vy2) + 48'(n_uy));
        end else begin
            n_out.new_first_vx  = r_s5_body.vx1;
            n_out.new_first_vy  = r_s5_body.vy1;
            n_out.new_second_vx = r_s5_body.vx2;
            n_out.new_second_vy = r_s5_body.vy2;
        end
    end

    // Advance valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else if (i_en) begin
            r_valid <= {r_valid[4:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s1_body <= i_body;
            r_s1_nx   <= n_nx;
            r_s1_ny   <= n_ny;
            r_s1_ov   <= $signed({1'b0, i_body.comb}) - $signed({1'b0, i_body.center_dist});
            r_s1_dvx  <= 33'(i_body.vx2) - 33'(i_body.vx1);
            r_s1_dvy  <= 33'(i_body.vy2) - 33'(i_body.vy1);

            r_s2_body <= r_s1_body;
            r_s2_nx   <= r_s1_nx;
            r_s2_ny   <= r_s1_ny;
            r_s2_px   <= 51'(r_s1_nx) * 51'(r_s1_ov);
            r_s2_py   <= 51'(r_s1_ny) * 51'(r_s1_ov);
            r_s2_qx   <= 51'(r_s1_dvx) * 51'(r_s1_nx);
            r_s2_qy   <= 51'(r_s1_dvy) * 51'(r_s1_ny);

            r_s3_body   <= r_s2_body;
            r_s3_nx     <= r_s2_nx;
            r_s3_ny     <= r_s2_ny;
            r_s3_appr   <= r_s2_body.contact && n_rel[51];
            r_s3_negrel <= 36'(-n_rel);
            if (r_s2_body.contact) begin
                r_s3_x1 <= sat_q16(48'(r_s2_body.x1) - 48'(n_ox));
                r_s3_y1 <= sat_q16(48'(r_s2_body.y1) - 48'(n_oy));
                r_s3_x2 <= sat_q16(48'(r_s2_body.x2) + 48'(n_ox));
                r_s3_y2 <= sat_q16(48'(r_s2_body.y2) + 48'(n_oy));
            end else begin
                r_s3_x1 <= r_s2_body.x1;
                r_s3_y1 <= r_s2_body.y1;
                r_s3_x2 <= r_s2_body.x2;
                r_s3_y2 <= r_s2_body.y2;
            end

            r_s4_body <= r_s3_body;
            r_s4_nx   <= r_s3_nx;
            r_s4_ny   <= r_s3_ny;
            r_s4_x1   <= r_s3_x1;
            r_s4_y1   <= r_s3_y1;
            r_s4_x2   <= r_s3_x2;
            r_s4_y2   <= r_s3_y2;
            r_s4_appr <= r_s3_appr;
            r_s4_imp  <= n_impp[53:16];

            r_s5_body <= r_s4_body;
            r_s5_x1   <= r_s4_x1;
            r_s5_y1   <= r_s4_y1;
            r_s5_x2   <= r_s4_x2;
            r_s5_y2   <= r_s4_y2;
            r_s5_appr <= r_s4_appr;
            r_s5_uxp  <= 57'(r_s4_nx) * $signed({19'd0, r_s4_imp});
            r_s5_uyp  <= 57'(r_s4_ny) * $signed({19'd0, r_s4_imp});

            r_out <= n_out;
        end
    end

    assign o_valid  = r_valid[5];
    assign o_result = r_out;

    // Impulse only follows a resolved contact
    `CPCR_ASSERT_SAME(a_appr_needs_contact, i_clk, i_rst_n, r_valid[5] && r_out.approaching, r_out.contact)
    // Without contact the positions pass through
    `CPCR_ASSERT_NEXT(a_no_contact_pos, i_clk, i_rst_n, i_en && r_valid[4] && !r_s5_body.contact, r_out.new_first_x == $past(r_s5_body.x1) && r_out.new_second_y == $past(r_s5_body.y2))
    // Without approach the velocities pass through
    `CPCR_ASSERT_NEXT(a_no_appr_vel, i_clk, i_rst_n, i_en && r_valid[4] && !r_s5_appr, r_out.new_first_vx == $past(r_s5_body.vx1) && r_out.new_second_vy == $past(r_s5_body.vy2))

endmodule

// File: sv/circle_pair_collision_response_unit.sv
// Pipeline: front stages, square root, divide and resolve, in that order, from an accepted request to its result.
// Throughput: one request per cycle; every stage advances together while the output is free.
// The output register holds a result while the sink stalls; the pipeline stops behind it.
// Reset (synchronous, active low) clears all stage valid bits and loads the default registers.
`timescale 1ns / 1ps

module circle_pair_collision_response_unit (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Request stream
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    // tdata: first_x, first_y, first_vx, first_vy, first_radius(31), second_x,
    //        second_y, second_vx, second_vy, second_radius(31), 2 zero bits
    input  logic [319:0] i_s_tdata,
    // Result stream
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // tdata: new_first_x, new_first_y, new_first_vx, new_first_vy,
    //        new_second_x, new_second_y, new_second_vx, new_second_vy
    output logic [255:0] o_m_tdata,
    // tuser: contact, approaching
    output logic [1:0]   o_m_tuser,
    // Configuration writes
    input  logic         i_cfg_we,
    input  logic         i_cfg_index,
    input  logic [16:0]  i_cfg_data
);
    import cpcr_pkg::*;

    logic [16:0] r_restitution;
    logic [16:0] r_min_distance;

    logic        w_en;
    t_pair       w_pair;
    logic        w_f_valid, w_q_valid, w_d_valid, w_o_valid;
    t_body       w_f_body, w_q_body, w_d_body;
    logic [63:0] w_radicand;
    logic [QUOT_BITS-1:0] w_qx, w_qy;
    t_result     w_result;

    // Configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_restitution  <= 17'd52429;
            r_min_distance <= 17'd0;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_RESTITUTION:  r_restitution  <= i_cfg_data;
                CFG_MIN_DISTANCE: r_min_distance <= i_cfg_data;
                default:          r_restitution  <= r_restitution;
            endcase
        end
    end

    // Advance whenever the output register is empty or being drained
    assign w_en       = !w_o_valid || i_m_tready;
    assign o_s_tready = w_en;

    // Unpack the request
    assign w_pair.first_x       = i_s_tdata[31:0];
    assign w_pair.first_y       = i_s_tdata[63:32];
    assign w_pair.first_vx      = i_s_tdata[95:64];
    assign w_pair.first_vy      = i_s_tdata[127:96];
    assign w_pair.first_radius  = i_s_tdata[158:128];
    assign w_pair.second_x      = i_s_tdata[190:159];
    assign w_pair.second_y      = i_s_tdata[222:191];
    assign w_pair.second_vx     = i_s_tdata[254:223];
    assign w_pair.second_vy     = i_s_tdata[286:255];
    assign w_pair.second_radius = i_s_tdata[317:287];

    cpcr_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (i_s_tvalid),
        .i_pair     (w_pair),
        .o_valid    (w_f_valid),
        .o_body     (w_f_body),
        .o_radicand (w_radicand)
    );

    cpcr_isqrt u_isqrt (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_en       (w_en),
        .i_valid    (w_f_valid),
        .i_body     (w_f_body),
        .i_radicand (w_radicand),
        .o_valid    (w_q_valid),
        .o_body     (w_q_body)
    );

    cpcr_div u_div (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (w_en),
        .i_valid        (w_q_valid),
        .i_body         (w_q_body),
        .i_min_distance (r_min_distance),
        .o_valid        (w_d_valid),
        .o_body         (w_d_body),
        .o_qx           (w_qx),
        .o_qy           (w_qy)
    );

    cpcr_resolve u_resolve (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_en          (w_en),
        .i_valid       (w_d_valid),
        .i_body        (w_d_body),
        .i_qx          (w_qx),
        .i_qy          (w_qy),
        .i_restitution (r_restitution),
        .o_valid       (w_o_valid),
        .o_result      (w_result)
    );

    // Pack the result
    assign o_m_tvalid = w_o_valid;
    assign o_m_tdata  = {w_result.new_second_vy, w_result.new_second_vx,
                         w_result.new_second_y,  w_result.new_second_x,
                         w_result.new_first_vy,  w_result.new_first_vx,
                         w_result.new_first_y,   w_result.new_first_x};
    assign o_m_tuser  = {w_result.approaching, w_result.contact};

endmodule

// File: tb/circle_pair_collision_response_unit_tb.sv
// Self-checking bench for the circle pair collision response unit: directed pairs, then
// random pairs under several restitution and minimum distance settings, random stalls.
// Depends on cpcr_pkg and the circle_pair_collision_response_unit RTL.
`timescale 1ns / 1ps

module circle_pair_collision_response_unit_tb;
    import cpcr_pkg::*;

    localparam int RANDOM_PER_PHASE = 160;
    localparam int DRAIN_CYCLES     = 80;
    localparam int HOLD_CYCLES      = 300;

    logic         i_clk = 1'b0;
    logic         i_rst_n;
    logic         i_s_tvalid;
    logic         o_s_tready;
    logic [319:0] i_s_tdata;
    logic         o_m_tvalid;
    logic         i_m_tready;
    logic [255:0] o_m_tdata;
    logic [1:0]   o_m_tuser;
    logic         i_cfg_we;
    logic         i_cfg_index;
    logic [16:0]  i_cfg_data;

    // Expected resolved pairs, oldest first
    t_result     resolved_q[$];
    int          fail_count = 0;
    logic [16:0] bounce_reg;
    logic [16:0] min_dist_reg;
    bit          sink_hold_req = 1'b0;
    bit          no_gaps = 1'b0;

    // Directed table, and the typed expectation that travels with the offered request
    t_pair       dir_rows[$];
    bit          dir_typed[$];
    logic        row_typed;
    t_result     row_want;

    circle_pair_collision_response_unit u_dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_s_tdata  (i_s_tdata),
        .o_m_tvalid (o_m_tvalid),
        .i_m_tready (i_m_tready),
        .o_m_tdata  (o_m_tdata),
        .o_m_tuser  (o_m_tuser),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_index(i_cfg_index),
        .i_cfg_data (i_cfg_data)
    );

    always #2 i_clk = ~i_clk;

    // Hard stop if the run hangs
    initial begin
        #4_000_000;
        $display("status: fail");
        $finish;
    end

    function automatic longint shr_tz(input longint v, input int k);
        if (v < 0) return -longint'(longint'(unsigned'(-v)) >>> 0 >> k);
        return v >> k;
    endfunction

    function automatic longint div_tz(input longint num, input longint unsigned den);
        longint unsigned mag;
        mag = (num < 0) ? longint'(-num) : num;
        if (num < 0) return -longint'(mag / den);
        return longint'(mag / den);
    endfunction

    function automatic longint unsigned int_sqrt(input longint unsigned v);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'h4000_0000_0000_0000;
        while (bitv > v) bitv = bitv >> 2;
        while (bitv != 0) begin
            if (v >= res + bitv) begin
                v   = v - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

    function automatic logic signed [31:0] clamp32(input longint v);
        if (v > 64'sd2147483647) return 32'sh7FFF_FFFF;
        if (v < -64'sd2147483648) return 32'sh8000_0000;
        return v[31:0];
    endfunction

    // Resolve one pair with the current register values
    function automatic t_result resolve_pair(input t_pair p);
        t_result r;
        longint x1, y1, vx1, vy1, x2, y2, vx2, vy2, dx, dy;
        longint nx, ny, overlap, ox, oy, rel, imp, ux, uy;
        longint unsigned comb, adx, ady, comb2, dx2, dy2, center_dist, rest;
        bit hit, closing;
        x1 = p.first_x;  y1 = p.first_y;  vx1 = p.first_vx;  vy1 = p.first_vy;
        x2 = p.second_x; y2 = p.second_y; vx2 = p.second_vx; vy2 = p.second_vy;
        comb = longint'(p.first_radius) + longint'(p.second_radius);
        dx = x2 - x1;
        dy = y2 - y1;
        adx = (dx < 0) ? -dx : dx;
        ady = (dy < 0) ? -dy : dy;
        hit = 1'b0;
        closing = 1'b0;
        if (adx < comb && ady < comb) begin
            comb2 = comb * comb;
            dx2 = adx * adx;
            dy2 = ady * ady;
            if (dy2 < comb2 - dx2) begin
                center_dist = int_sqrt(dx2 + dy2);
                hit = (center_dist < comb) && (center_dist > longint'(min_dist_reg));
                if (hit) begin
                    nx = div_tz(dx * 65536, center_dist);
                    ny = div_tz(dy * 65536, center_dist);
                    overlap = longint'(comb - center_dist);
                    ox = shr_tz(nx * overlap, 17);
                    oy = shr_tz(ny * overlap, 17);
                    rel = shr_tz((vx2 - vx1) * nx + (vy2 - vy1) * ny, 16);
                    x1 -= ox; y1 -= oy;
                    x2 += ox; y2 += oy;
                    if (rel < 0) begin
                        // Bounce factor above one acts as one
                        rest = (bounce_reg > RESTITUTION_ONE) ? 65536 : longint'(bounce_reg);
                        imp = longint'(((65536 + rest) * longint'(-rel)) >> 16);
                        ux = shr_tz(nx * imp, 17);
                        uy = shr_tz(ny * imp, 17);
                        closing = 1'b1;
                        vx1 -= ux; vy1 -= uy;
                        vx2 += ux; vy2 += uy;
                    end
                end
            end
        end
        r.new_first_x   = clamp32(x1);
        r.new_first_y   = clamp32(y1);
        r.new_first_vx  = clamp32(vx1);
        r.new_first_vy  = clamp32(vy1);
        r.new_second_x  = clamp32(x2);
        r.new_second_y  = clamp32(y2);
        r.new_second_vx = clamp32(vx2);
        r.new_second_vy = clamp32(vy2);
        r.contact       = hit;
        r.approaching   = closing;
        return r;
    endfunction

    function automatic t_pair make_pair(input logic [31:0] x1, y1, vx1, vy1,
                                        input logic [30:0] r1,
                                        input logic [31:0] x2, y2, vx2, vy2,
                                        input logic [30:0] r2);
        t_pair p;
        p.first_x = x1;  p.first_y = y1;  p.first_vx = vx1;  p.first_vy = vy1;
        p.first_radius = r1;
        p.second_x = x2; p.second_y = y2; p.second_vx = vx2; p.second_vy = vy2;
        p.second_radius = r2;
        return p;
    endfunction

    // Append one directed row
    function automatic void add_row(input t_pair p, input bit typed);
        dir_rows.insert(dir_rows.size(), p);
        dir_typed.insert(dir_typed.size(), typed);
    endfunction

    // Both particles unchanged, both flags low
    function automatic t_result pass_through(input t_pair p);
        t_result r;
        r.new_first_x   = p.first_x;   r.new_first_y   = p.first_y;
        r.new_first_vx  = p.first_vx;  r.new_first_vy  = p.first_vy;
        r.new_second_x  = p.second_x;  r.new_second_y  = p.second_y;
        r.new_second_vx = p.second_vx; r.new_second_vy = p.second_vy;
        r.contact       = 1'b0;
        r.approaching   = 1'b0;
        return r;
    endfunction

    function automatic logic [31:0] pick_extreme();
        case ($urandom_range(0, 4))
            0: return 32'h0000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h8000_0000;
            3: return 32'hFFFF_FFFF;
            default: return 32'h0000_0001;
        endcase
    endfunction

    function automatic logic [31:0] rand_speed();
        return $signed($urandom) >>> $urandom_range(0, 16);
    endfunction

    // Mostly pairs near contact, some raw noise, some extremes
    function automatic t_pair rand_pair();
        t_pair p;
        int     mode;
        longint span, dx, dy;
        logic [31:0] x1, y1;
        logic [30:0] r1, r2;
        mode = $urandom_range(0, 99);
        if (mode < 70) begin
            case ($urandom_range(0, 9))
                0: begin
                    r1 = 31'($urandom);
                    r2 = 31'($urandom);
                end
                1, 2: begin
                    r1 = 31'($urandom_range(0, 1 << 17));
                    r2 = 31'($urandom_range(0, 1 << 17));
                end
                default: begin
                    r1 = 31'($urandom_range(0, 1 << 21));
                    r2 = 31'($urandom_range(0, 1 << 21));
                end
            endcase
            span = longint'(r1) + longint'(r2);
            if (span > (64'sd1 << 30)) span = 64'sd1 << 30;
            dx = longint'($urandom % (2 * span + 1)) - span;
            dy = longint'($urandom % (2 * span + 1)) - span;
            x1 = ($urandom_range(0, 3) == 0) ? $urandom : ($signed($urandom) >>> 3);
            y1 = ($urandom_range(0, 3) == 0) ? $urandom : ($signed($urandom) >>> 3);
            p = make_pair(x1, y1, rand_speed(), rand_speed(), r1,
                          x1 + dx[31:0], y1 + dy[31:0], rand_speed(), rand_speed(), r2);
        end else if (mode < 85) begin
            p = make_pair($urandom, $urandom, $urandom, $urandom, 31'($urandom),
                          $urandom, $urandom, $urandom, $urandom, 31'($urandom));
        end else begin
            p = make_pair(pick_extreme(), pick_extreme(), pick_extreme(), pick_extreme(),
                          31'(pick_extreme()), pick_extreme(), pick_extreme(),
                          pick_extreme(), pick_extreme(), 31'(pick_extreme()));
        end
        return p;
    endfunction

    function automatic int rand_gap();
        int k;
        k = $urandom_range(0, 99);
        if (no_gaps || k < 60) return 0;
        if (k < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    // Offer one request and hold it until accepted
    task automatic send_pair(input t_pair p);
        int gap;
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {2'b00, p.second_radius, p.second_vy, p.second_vx, p.second_y,
                       p.second_x, p.first_radius, p.first_vy, p.first_vx, p.first_y,
                       p.first_x};
        do @(posedge i_clk); while (!o_s_tready);
        gap = rand_gap();
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // Drain the pipeline, then write one register
    task automatic write_reg(input logic idx, input logic [16:0] val);
        i_s_tvalid <= 1'b0;
        while (resolved_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_RESTITUTION) bounce_reg = val;
        else min_dist_reg = val;
    endtask

    // Predict on each accepted request, check each accepted result
    always @(posedge i_clk) begin
        t_pair   req;
        t_result got, want;
        longint  g[10], w[10];
        string   names[10];
        if (i_rst_n) begin
            if (o_m_tvalid && i_m_tready) begin
                got.new_first_x   = o_m_tdata[31:0];
                got.new_first_y   = o_m_tdata[63:32];
                got.new_first_vx  = o_m_tdata[95:64];
                got.new_first_vy  = o_m_tdata[127:96];
                got.new_second_x  = o_m_tdata[159:128];
                got.new_second_y  = o_m_tdata[191:160];
                got.new_second_vx = o_m_tdata[223:192];
                got.new_second_vy = o_m_tdata[255:224];
                got.contact       = o_m_tuser[0];
                got.approaching   = o_m_tuser[1];
                if (resolved_q.size() == 0) begin
                    $display("%0t: expected none, actual %h", $time, got);
                    fail_count++;
                end else begin
                    want = resolved_q.pop_front();
                    names = '{"new_first_x", "new_first_y", "new_first_vx", "new_first_vy",
                              "new_second_x", "new_second_y", "new_second_vx",
                              "new_second_vy", "contact", "approaching"};
                    g = '{got.new_first_x, got.new_first_y, got.new_first_vx,
                          got.new_first_vy, got.new_second_x, got.new_second_y,
                          got.new_second_vx, got.new_second_vy, got.contact,
                          got.approaching};
                    w = '{want.new_first_x, want.new_first_y, want.new_first_vx,
                          want.new_first_vy, want.new_second_x, want.new_second_y,
                          want.new_second_vx, want.new_second_vy, want.contact,
                          want.approaching};
                    for (int i = 0; i < 10; i++) begin
                        if (g[i] != w[i]) begin
                            $display("%0t: %s expected %0d actual %0d", $time, names[i],
                                     w[i], g[i]);
                            fail_count++;
                        end
                    end
                end
            end
            if (i_s_tvalid && o_s_tready) begin
                req.first_x       = i_s_tdata[31:0];
                req.first_y       = i_s_tdata[63:32];
                req.first_vx      = i_s_tdata[95:64];
                req.first_vy      = i_s_tdata[127:96];
                req.first_radius  = i_s_tdata[158:128];
                req.second_x      = i_s_tdata[190:159];
                req.second_y      = i_s_tdata[222:191];
                req.second_vx     = i_s_tdata[254:223];
                req.second_vy     = i_s_tdata[286:255];
                req.second_radius = i_s_tdata[317:287];
                if (row_typed) begin
                    resolved_q.insert(resolved_q.size(), row_want);
                end else begin
                    resolved_q.insert(resolved_q.size(), resolve_pair(req));
                end
            end
        end
    end

    // Sink: random ready bursts and stalls, one long hold-off on request
    initial begin
        int hold;
        i_m_tready <= 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (sink_hold_req) begin
                i_m_tready <= 1'b0;
                hold = 0;
                while (hold < HOLD_CYCLES) begin
                    @(posedge i_clk);
                    hold++;
                end
                sink_hold_req = 1'b0;
            end
            i_m_tready <= 1'b1;
            repeat ($urandom_range(1, 30)) @(posedge i_clk);
            if ($urandom_range(0, 3) != 0) begin
                i_m_tready <= 1'b0;
                repeat (($urandom_range(0, 9) == 0) ? $urandom_range(10, 40)
                                                    : $urandom_range(1, 3)) @(posedge i_clk);
            end
        end
    end

    // Stimulus
    initial begin
        logic [16:0] bounce_set[5];
        logic [16:0] min_set[5];
        t_pair       p;

        i_rst_n     <= 1'b0;
        i_s_tvalid  <= 1'b0;
        i_s_tdata   <= '0;
        i_cfg_we    <= 1'b0;
        i_cfg_index <= CFG_RESTITUTION;
        i_cfg_data  <= '0;
        row_typed   <= 1'b0;
        row_want    <= '0;
        bounce_reg   = 17'd52429;
        min_dist_reg = 17'd0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Coincident centres: never a contact
        add_row(make_pair(0, 0, 32'h0001_0000, 0, 31'h0001_0000,
                          0, 0, 32'hFFFF_0000, 0, 31'h0001_0000), 1'b1);
        // Far apart
        add_row(make_pair(32'h8000_0000, 0, 5, 6, 31'h0000_1000,
                          32'h7FFF_FFFF, 0, 7, 8, 31'h0000_1000), 1'b1);
        // All maxima, centres coincide
        add_row(make_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                          32'h7FFF_FFFF, 31'h7FFF_FFFF, 32'h7FFF_FFFF,
                          32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                          31'h7FFF_FFFF), 1'b1);
        // All minima, zero radii
        add_row(make_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                          32'h8000_0000, 31'd0, 32'h8000_0000, 32'h8000_0000,
                          32'h8000_0000, 32'h8000_0000, 31'd0), 1'b1);
        // Head-on approach
        add_row(make_pair(0, 0, 32'h0001_0000, 0, 31'h0001_0000,
                          32'h0001_0000, 0, 32'hFFFF_0000, 0, 31'h0001_0000), 1'b0);
        // Overlap while separating
        add_row(make_pair(0, 0, 32'hFFFF_0000, 0, 31'h0001_0000,
                          32'h0001_0000, 0, 32'h0001_0000, 0, 31'h0001_0000), 1'b0);
        // Just touching: distance equals the radius sum
        add_row(make_pair(0, 0, 0, 0, 31'h0001_0000,
                          32'h0002_0000, 0, 0, 0, 31'h0001_0000), 1'b0);
        // Position push-out saturates
        add_row(make_pair(32'h8000_0000, 0, 0, 0, 31'h4000_0000,
                          32'h8001_0000, 0, 0, 0, 31'h4000_0000), 1'b0);
        // Velocity impulse saturates
        add_row(make_pair(0, 0, 32'h7FFF_FFFF, 0, 31'h0010_0000,
                          32'h0001_0000, 0, 32'h8000_0000, 0, 31'h0010_0000), 1'b0);
        // Diagonal contact
        add_row(make_pair(32'h0003_0000, 32'hFFFE_0000, 32'h0000_8000,
                          32'h0000_4000, 31'h0002_0000, 32'h0004_8000,
                          32'hFFFF_0000, 32'hFFFF_C000, 32'h0000_2000,
                          31'h0001_8000), 1'b0);
        // Tiny distance, just above zero
        add_row(make_pair(0, 0, 32'h0000_0100, 0, 31'h0000_0800,
                          32'h0000_0064, 0, 0, 0, 31'h0000_0800), 1'b0);
        // Largest radii with a small offset
        add_row(make_pair(0, 0, 32'h0100_0000, 32'hFF00_0000, 31'h7FFF_FFFF,
                          32'h0000_1234, 32'hFFFF_F000, 32'hFF00_0000,
                          32'h0100_0000, 31'h7FFF_FFFF), 1'b0);

        write_reg(CFG_RESTITUTION, 17'd52429);
        write_reg(CFG_MIN_DISTANCE, 17'd0);
        foreach (dir_rows[i]) begin
            row_typed <= dir_typed[i];
            row_want  <= pass_through(dir_rows[i]);
            send_pair(dir_rows[i]);
        end
        // Wait out every result before the random part
        i_s_tvalid <= 1'b0;
        row_typed  <= 1'b0;
        while (resolved_q.size() != 0) @(posedge i_clk);

        bounce_set = '{17'd52429, 17'd0, 17'd65536, 17'd131071, 17'($urandom)};
        min_set    = '{17'd0, 17'd65536, 17'd1, 17'd0, 17'($urandom_range(0, 65536))};
        for (int ph = 0; ph < 5; ph++) begin
            write_reg(CFG_RESTITUTION, bounce_set[ph]);
            write_reg(CFG_MIN_DISTANCE, min_set[ph]);
            for (int n = 0; n < RANDOM_PER_PHASE; n++) begin
                // Back-to-back stretch, and one long sink hold-off in the third phase
                if (n == 40) no_gaps = 1'b1;
                if (n == 90) no_gaps = 1'b0;
                if (ph == 2 && n == 50) sink_hold_req = 1'b1;
                p = rand_pair();
                send_pair(p);
            end
        end

        // Drain and settle
        i_s_tvalid <= 1'b0;
        while (resolved_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0 && resolved_q.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+sv
sv/cpcr_pkg.sv
sv/cpcr_front.sv
sv/cpcr_isqrt.sv
sv/cpcr_div.sv
sv/cpcr_resolve.sv
sv/circle_pair_collision_response_unit.sv
tb/circle_pair_collision_response_unit_tb.sv
